[hdl/pfr_pkg.sv]
// ============================================================================
// pfr_pkg: shared types and constants for the PCM frame resampler
// Register indexes, field widths, rate limits and the sequencer state type.
// ============================================================================
package pfr_pkg;

   localparam int SAMPLE_W = 16;
   localparam int RATE_W   = 19;
   localparam int ACC_W    = 19;
   localparam int SUM_W    = 20;
   localparam int CSR_IDX_W = 2;

   localparam logic [RATE_W-1:0] RATE_MIN = 19'd1000;
   localparam logic [RATE_W-1:0] RATE_MAX = 19'd384000;
   localparam logic [RATE_W-1:0] RATE_RESET = 19'd44100;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INPUT_RATE  = 2'd0,
      CSR_SIXTEEN_BIT = 2'd1,
      CSR_MONO_INPUT  = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_LOOK  = 5'b00100,
      ST_SEND  = 5'b01000,
      ST_FIN   = 5'b10000
   } state_type;

endpackage

[hdl/pcm_frame_resampler_to_44k_stereo.sv]
// ============================================================================
// pcm_frame_resampler_to_44k_stereo: nearest-neighbor rate converter
// Repeats or drops PCM input frames to give OUT_RATE Hz stereo 16-bit frames.
// ============================================================================
//
// Usage: one input request on req_* carries one PCM frame (two raw samples,
// tlast marks the last frame of a stream). For each request the block emits
// zero or more stereo frames on rsp_*; rsp_tlast is set on the last frame
// that the request produced. Output frame k repeats input frame
// floor(k * rate / OUT_RATE), tracked with a phase accumulator. On the final
// frame only outputs that fit the stream length are emitted, then the
// accumulator clears.
// Structure: one shared adder under a five-state sequencer. A request goes
// through check, then look and send per output frame (send waits out any
// receiver stall), then fin; a 1000 Hz input rate gives up to 45 outputs.
// req_tready is high only while the sequencer is idle.
// The configuration port (csr_*) is always ready; index 0 is the input rate
// (saturated to 1000..384000 when used), 1 selects signed 16-bit samples,
// 2 selects mono. Writes are expected only while the block is idle.
// Reset is synchronous: registers return to 44100 Hz, 16-bit, stereo, the
// accumulator clears and the sequencer goes idle. When the receiver stalls,
// the pending output frame is held unchanged on rsp_tdata and rsp_tlast.
//
module pcm_frame_resampler_to_44k_stereo #(
   parameter int OUT_RATE = 44100
) (
   input  logic                             clock,
   input  logic                             reset,
   // Input frames
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [31:0]                      req_tdata,  // first_sample, second_sample
   input  logic                             req_tlast,  // final_frame
   // Output frames
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [31:0]                      rsp_tdata,  // left_out, right_out
   output logic                             rsp_tlast,  // run_end
   // Configuration writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pfr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pfr_pkg::RATE_W-1:0]       csr_data
);

   // The output rate as a compare constant and as its negation for the
   // wraparound subtraction done by the shared adder.
   localparam logic [pfr_pkg::SUM_W-1:0] OUT_W   = pfr_pkg::SUM_W'(OUT_RATE);
   localparam logic [pfr_pkg::SUM_W-1:0] OUT_NEG =
      pfr_pkg::SUM_W'((2 ** pfr_pkg::SUM_W) - OUT_RATE);

   // Configuration registers.
   logic [pfr_pkg::RATE_W-1:0]   cfg_rate_ff, cfg_rate_in;
   logic                         cfg_sixteen_ff, cfg_sixteen_in;
   logic                         cfg_mono_ff, cfg_mono_in;

   // Sequencer and datapath registers. The running phase can pass one output
   // period by up to one input rate, so it is kept at the adder's width.
   pfr_pkg::state_type           state_ff, state_in;
   logic [pfr_pkg::SUM_W-1:0]    acc_ff, acc_in;
   logic [pfr_pkg::RATE_W-1:0]   rate_ff, rate_in;
   logic                         final_ff, final_in;
   logic [pfr_pkg::SAMPLE_W-1:0] left_ff, left_in;
   logic [pfr_pkg::SAMPLE_W-1:0] right_ff, right_in;
   logic                         last_ff, last_in;
   logic                         more_ff, more_in;

   logic [pfr_pkg::SUM_W-1:0]    add_b;
   logic [pfr_pkg::SUM_W-1:0]    sum;
   logic                         emit_ok;
   logic                         req_fire;
   logic                         rsp_fire;
   logic [pfr_pkg::RATE_W-1:0]   rate_clamped;
   logic [pfr_pkg::SAMPLE_W-1:0] dec_first;
   logic [pfr_pkg::SAMPLE_W-1:0] dec_second;

   // Unsigned 8-bit samples map to (b - 128) * 256, which in 16-bit two's
   // complement is the byte with its top bit flipped, shifted up by 8.
   function automatic logic [pfr_pkg::SAMPLE_W-1:0] decode_sample(
      input logic [pfr_pkg::SAMPLE_W-1:0] raw,
      input logic                         wide
   );
      logic [pfr_pkg::SAMPLE_W-1:0] res;
      if (wide) begin
         res = raw;
      end else begin
         res = {~raw[7], raw[6:0], 8'h00};
      end
      return res;
   endfunction

   assign req_tready = (state_ff == pfr_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == pfr_pkg::ST_SEND);
   assign rsp_tdata  = {right_ff, left_ff};
   assign rsp_tlast  = last_ff;
   assign csr_ready  = 1'b1;

   assign req_fire = req_tvalid & req_tready;
   assign rsp_fire = rsp_tvalid & rsp_tready;

   always_comb begin
      if (cfg_rate_ff < pfr_pkg::RATE_MIN) begin
         rate_clamped = pfr_pkg::RATE_MIN;
      end else if (cfg_rate_ff > pfr_pkg::RATE_MAX) begin
         rate_clamped = pfr_pkg::RATE_MAX;
      end else begin
         rate_clamped = cfg_rate_ff;
      end
   end

   assign dec_first  = decode_sample(req_tdata[15:0], cfg_sixteen_ff);
   assign dec_second = cfg_mono_ff ? dec_first
                                   : decode_sample(req_tdata[31:16], cfg_sixteen_ff);

   // The one shared adder: it steps the phase by the input rate while
   // outputs are produced, and takes off one output period at the end.
   assign add_b = (state_ff == pfr_pkg::ST_FIN) ? OUT_NEG
                                                : {1'b0, rate_ff};
   assign sum   = acc_ff + add_b;

   // An output is due while the phase lies inside the current input frame;
   // on the final frame it must also end within the stream.
   assign emit_ok = (acc_ff < OUT_W) && !(final_ff && (sum > OUT_W));

   always_comb begin
      cfg_rate_in    = cfg_rate_ff;
      cfg_sixteen_in = cfg_sixteen_ff;
      cfg_mono_in    = cfg_mono_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            pfr_pkg::CSR_INPUT_RATE:  cfg_rate_in    = csr_data;
            pfr_pkg::CSR_SIXTEEN_BIT: cfg_sixteen_in = csr_data[0];
            pfr_pkg::CSR_MONO_INPUT:  cfg_mono_in    = csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      rate_in  = rate_ff;
      final_in = final_ff;
      left_in  = left_ff;
      right_in = right_ff;
      last_in  = last_ff;
      more_in  = more_ff;
      case (state_ff)
         pfr_pkg::ST_IDLE: begin
            if (req_fire) begin
               rate_in  = rate_clamped;
               final_in = req_tlast;
               left_in  = dec_first;
               right_in = dec_second;
               state_in = pfr_pkg::ST_CHECK;
            end
         end
         pfr_pkg::ST_CHECK: begin
            if (emit_ok) begin
               acc_in   = sum;
               state_in = pfr_pkg::ST_LOOK;
            end else begin
               state_in = pfr_pkg::ST_FIN;
            end
         end
         pfr_pkg::ST_LOOK: begin
            // Look one output ahead so run_end is known when the frame shows.
            more_in  = emit_ok;
            last_in  = !emit_ok;
            state_in = pfr_pkg::ST_SEND;
         end
         pfr_pkg::ST_SEND: begin
            if (rsp_fire) begin
               if (more_ff) begin
                  acc_in   = sum;
                  state_in = pfr_pkg::ST_LOOK;
               end else begin
                  state_in = pfr_pkg::ST_FIN;
               end
            end
         end
         pfr_pkg::ST_FIN: begin
            // A non-final frame always stops with the phase past one period.
            acc_in   = final_ff ? '0 : sum;
            state_in = pfr_pkg::ST_IDLE;
         end
         default: begin
            state_in = pfr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= pfr_pkg::ST_IDLE;
         acc_ff         <= '0;
         cfg_rate_ff    <= pfr_pkg::RATE_RESET;
         cfg_sixteen_ff <= 1'b1;
         cfg_mono_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         acc_ff         <= acc_in;
         cfg_rate_ff    <= cfg_rate_in;
         cfg_sixteen_ff <= cfg_sixteen_in;
         cfg_mono_ff    <= cfg_mono_in;
      end
   end

   always_ff @(posedge clock) begin
      rate_ff  <= rate_in;
      final_ff <= final_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      last_ff  <= last_in;
      more_ff  <= more_in;
   end

`ifndef SYNTHESIS
   // Input and output sides are never open together.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("output pending while accepting input");

   // A taken request closes the input until its outputs are done.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted twice in a row");

   // After each delivered frame the sequencer steps away from the output.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready) |=> !rsp_tvalid)
      else $error("output frame repeated without a new look-ahead");

   // The phase is back at zero once a final frame has been handled.
   assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff == pfr_pkg::ST_FIN) && $past(final_ff) && !$past(reset))
      |-> (acc_ff == '0))
      else $error("phase not cleared after final frame");
`endif

endmodule
